// File: sv/vic_pkg.sv
`default_nettype none

package vic_pkg;

	// Plane store geometry and label width
	localparam int unsigned PLANE_DEPTH = 65536;
	localparam int unsigned LABEL_WIDTH = 32;
	localparam int unsigned ADDR_W      = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

	// Slot index y * size_z + z never exceeds 1023 * 1024 + 1023
	localparam int unsigned SLOT_W = 20;

	localparam logic [SLOT_W:0] DEPTH_LIMIT = (SLOT_W + 1)'(PLANE_DEPTH);

	typedef logic [LABEL_WIDTH-1:0] label_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [SLOT_W-1:0]      slot_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SIZE_X = 2'd0,
		CFG_SIZE_Y = 2'd1,
		CFG_SIZE_Z = 2'd2
	} cfg_idx_t;

	// Read request: slot of the voxel itself and slot one row back
	typedef struct packed {
		logic  en;
		addr_t addr_x;
		addr_t addr_y;
	} rd_req_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		label_t data;
	} wr_req_t;

	// Clamp a y or z size: zero acts as one, above 1024 acts as 1024
	function automatic logic [10:0] eff_size_yz(input logic [10:0] v);
		logic [10:0] r;
		r = v;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > 11'd1024) begin
			r = 11'd1024;
		end
		return r;
	endfunction

	function automatic logic [15:0] eff_size_x(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

`default_nettype wire

// File: sv/vic_plane_store.sv
`default_nettype none

module vic_plane_store
	import vic_pkg::*;
(
	input  wire logic    clk,
	input  wire rd_req_t rd,
	input  wire wr_req_t wr,
	output label_t       rd_data_x,
	output label_t       rd_data_y
);

	label_t mem [PLANE_DEPTH];

	label_t mem_x_q;
	label_t mem_y_q;
	label_t fwd_data_q;
	logic   fwd_x_q;
	logic   fwd_y_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read sees the old contents; bypass a write to the same entry in the same cycle
	always_ff @(posedge clk) begin
		if (rd.en) begin
			mem_x_q    <= mem[rd.addr_x];
			mem_y_q    <= mem[rd.addr_y];
			fwd_x_q    <= wr.en && (wr.addr == rd.addr_x);
			fwd_y_q    <= wr.en && (wr.addr == rd.addr_y);
			fwd_data_q <= wr.data;
		end
	end

	assign rd_data_x = fwd_x_q ? fwd_data_q : mem_x_q;
	assign rd_data_y = fwd_y_q ? fwd_data_q : mem_y_q;

endmodule

`default_nettype wire

// File: sv/voxel_interface_counter.sv
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  label
// result    out        out_valid/out_stall count_x, count_y, count_z
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One voxel per cycle while the input is not stalled; results pass stage 1, then the result register.
// The rate is set by the plane store: two reads at transfer, write back as stage 1
// retires, with a bypass when the write hits an entry being read.
// Reset clears positions, counters and pipeline state; sizes reset to one.
// The input stalls only when the last voxel of a volume meets a full, stalled result.
`default_nettype none

module voxel_interface_counter
	import vic_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] label,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [31:0] count_x,
	output logic             [31:0] count_y,
	output logic             [31:0] count_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic         [1:0] cfg_index,
	input  wire logic        [15:0] cfg_data
);

	// Effective sizes, clamped at write time
	logic [15:0] sx_q;
	logic [10:0] sy_q;
	logic [10:0] sz_q;

	// Raster position and base slot of the current row (pos_y * size_z)
	logic [15:0] pos_x_q;
	logic [9:0]  pos_y_q;
	logic [9:0]  pos_z_q;
	slot_t       row_base_q;
	label_t      prev_q;

	// Stage 1: compare and write back
	logic   valid_s1;
	label_t label_s1;
	addr_t  addr_s1;
	logic   wr_s1;
	logic   x_chk_s1;
	logic   y_chk_s1;
	logic   z_hit_s1;
	logic   last_s1;

	logic [31:0] acc_x_q;
	logic [31:0] acc_y_q;
	logic [31:0] acc_z_q;
	logic        out_valid_q;
	logic [31:0] cnt_x_q;
	logic [31:0] cnt_y_q;
	logic [31:0] cnt_z_q;

	logic        in_acc;
	logic        s1_go;
	logic        cfg_acc;
	label_t      v;
	slot_t       slot;
	slot_t       up;
	logic        in_store;
	logic        up_ok;
	logic        last_z;
	logic        last_y;
	logic        last_x;
	rd_req_t     rd;
	wr_req_t     wr;
	label_t      rd_data_x;
	label_t      rd_data_y;
	logic        x_hit;
	logic        y_hit;
	logic [31:0] acc_x_nx;
	logic [31:0] acc_y_nx;
	logic [31:0] acc_z_nx;
	logic [20:0] rebase;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// Hold the input only while a finished volume cannot hand off its result
	assign in_stall = valid_s1 && last_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign s1_go    = valid_s1 && !(last_s1 && out_valid_q && out_stall);

	assign v        = label[LABEL_WIDTH-1:0];
	assign slot     = row_base_q + SLOT_W'(pos_z_q);
	assign up       = slot - SLOT_W'(sz_q);
	assign in_store = {1'b0, slot} < DEPTH_LIMIT;
	assign up_ok    = (pos_y_q != 10'd0) && ({1'b0, up} < DEPTH_LIMIT);
	assign last_z   = ({1'b0, pos_z_q} + 11'd1) >= sz_q;
	assign last_y   = ({1'b0, pos_y_q} + 11'd1) >= sy_q;
	assign last_x   = ({1'b0, pos_x_q} + 17'd1) >= {1'b0, sx_q};

	// Issue both reads at transfer; write back when stage 1 retires
	assign rd.en     = in_acc;
	assign rd.addr_x = slot[ADDR_W-1:0];
	assign rd.addr_y = up[ADDR_W-1:0];
	assign wr.en     = s1_go && wr_s1;
	assign wr.addr   = addr_s1;
	assign wr.data   = label_s1;

	vic_plane_store u_store (
		.clk       (clk),
		.rd        (rd),
		.wr        (wr),
		.rd_data_x (rd_data_x),
		.rd_data_y (rd_data_y)
	);

	// Recompute the row base when size_z changes mid volume
	assign rebase = pos_y_q * eff_size_yz(cfg_data[10:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= 16'd1;
			sy_q <= 11'd1;
			sz_q <= 11'd1;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_SIZE_X: sx_q <= eff_size_x(cfg_data);
				CFG_SIZE_Y: sy_q <= eff_size_yz(cfg_data[10:0]);
				CFG_SIZE_Z: sz_q <= eff_size_yz(cfg_data[10:0]);
				default: ;
			endcase
		end
	end

	// Advance the raster position on every transfer that does not meet a size_z write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			pos_z_q    <= '0;
			row_base_q <= '0;
			prev_q     <= '0;
		end else if (cfg_acc && (cfg_index == CFG_SIZE_Z)) begin
			row_base_q <= rebase[SLOT_W-1:0];
		end else if (in_acc) begin
			prev_q <= v;
			if (!last_z) begin
				pos_z_q <= pos_z_q + 10'd1;
			end else begin
				pos_z_q <= '0;
				if (!last_y) begin
					pos_y_q    <= pos_y_q + 10'd1;
					row_base_q <= row_base_q + SLOT_W'(sz_q);
				end else begin
					pos_y_q    <= '0;
					row_base_q <= '0;
					pos_x_q    <= last_x ? 16'd0 : pos_x_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			label_s1 <= v;
			addr_s1  <= slot[ADDR_W-1:0];
			wr_s1    <= in_store;
			x_chk_s1 <= in_store && (pos_x_q != 16'd0);
			y_chk_s1 <= up_ok;
			z_hit_s1 <= (pos_z_q != 10'd0) && (v != prev_q);
			last_s1  <= last_z && last_y && last_x;
		end
	end

	assign x_hit = x_chk_s1 && (label_s1 != rd_data_x);
	assign y_hit = y_chk_s1 && (label_s1 != rd_data_y);

	// Saturating increments
	assign acc_x_nx = (x_hit && (acc_x_q != '1)) ? acc_x_q + 32'd1 : acc_x_q;
	assign acc_y_nx = (y_hit && (acc_y_q != '1)) ? acc_y_q + 32'd1 : acc_y_q;
	assign acc_z_nx = (z_hit_s1 && (acc_z_q != '1)) ? acc_z_q + 32'd1 : acc_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_z_q <= '0;
			end else begin
				acc_x_q <= acc_x_nx;
				acc_y_q <= acc_y_nx;
				acc_z_q <= acc_z_nx;
			end
		end
	end

	// Result register: load on the last voxel, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			cnt_x_q <= acc_x_nx;
			cnt_y_q <= acc_y_nx;
			cnt_z_q <= acc_z_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign count_x   = cnt_x_q;
	assign count_y   = cnt_y_q;
	assign count_z   = cnt_z_q;

endmodule

`default_nettype wire
